### sv/wmm_pkg.sv
// Shared types, constants and character helpers for the wildcard mask matcher.
`default_nettype none
package wmm_pkg;

	// Default mask capacity in characters
	localparam int unsigned MAX_PATTERN_DEF = 64;

	// Mask metacharacters
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_ANY1 = 8'h3F;

	// ASCII upper-case range for folding
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_NAME   = 2'd2,
		OP_END    = 2'd3
	} opcode_t;

	// Per-item control broadcast to every cell
	typedef struct packed {
		logic    fire;
		opcode_t op;
		logic [7:0] ch;
	} cell_ctl_t;

	// Signals handed from one cell to the next
	typedef struct packed {
		logic carry;   // reached position, passed on through a '*' matching nothing
		logic adv;     // position reached by consuming the current name character
	} link_t;

	typedef struct packed {
		logic is_match;
		logic mask_overflow;
	} result_t;

	function automatic logic [7:0] fold_char(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

	// One mask character against one name character ('*' masks handled by caller)
	function automatic logic char_ok(input logic [7:0] m, input logic [7:0] c);
		logic ok;
		if (c == CH_STAR) begin
			ok = 1'b0;
		end else if (m == CH_ANY1) begin
			ok = 1'b1;
		end else begin
			ok = (fold_char(m) == fold_char(c));
		end
		return ok;
	endfunction

endpackage
`default_nettype wire

### sv/wmm_ifs.sv
// Valid/ready channel interfaces for matcher requests and results.
`default_nettype none
interface wmm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] char_code;

	modport source (output valid, output opcode, output char_code, input ready);
	modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface wmm_rsp_if;
	logic valid;
	logic ready;
	logic is_match;
	logic mask_overflow;

	modport source (output valid, output is_match, output mask_overflow, input ready);
	modport sink (input valid, input is_match, input mask_overflow, output ready);
endinterface
`default_nettype wire

### sv/wmm_cell.sv
// One mask position: holds its mask character and active bit, links to its neighbor.
`default_nettype none
module wmm_cell #(
	parameter int unsigned MAX_PATTERN = wmm_pkg::MAX_PATTERN_DEF,
	parameter int unsigned POS = 0,
	localparam int unsigned LW = $clog2(MAX_PATTERN + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wmm_pkg::cell_ctl_t ctl,
	input  wire logic [LW-1:0]     len,
	input  wire wmm_pkg::link_t    link_in,
	output wmm_pkg::link_t         link_out,
	output logic                   hit
);
	import wmm_pkg::*;

	logic [7:0] char_q;
	logic       act_q;
	logic       used;
	logic       is_star;
	logic       closed;
	logic       nxt;

	// Closure and step for this position
	always_comb begin
		used           = (len > LW'(POS));
		is_star        = (char_q == CH_STAR);
		closed         = act_q | link_in.carry;
		link_out.carry = closed & used & is_star;
		link_out.adv   = closed & used & ~is_star & char_ok(char_q, ctl.ch);
		nxt            = link_out.carry | link_in.adv;
		hit            = closed & (len == LW'(POS));
	end

	// Active bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= (POS == 0);
		end else if (ctl.fire) begin
			unique case (ctl.op)
				OP_CLEAR, OP_END: act_q <= (POS == 0);
				OP_NAME:          act_q <= nxt;
				OP_APPEND:        act_q <= act_q;
			endcase
		end
	end

	// Mask character, written when the mask grows into this position
	always_ff @(posedge clk) begin
		if (ctl.fire && ctl.op == OP_APPEND && len == LW'(POS)) begin
			char_q <= ctl.ch;
		end
	end

endmodule
`default_nettype wire

### sv/wmm_out_buf.sv
// Result output register with one skid entry.
`default_nettype none
module wmm_out_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire wmm_pkg::result_t push_data,
	output logic                  ready,
	wmm_rsp_if.source             rsp
);
	import wmm_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    out_free;

	assign out_free = ~out_valid_q | rsp.ready;
	assign ready    = ~skid_valid_q;

	assign rsp.valid         = out_valid_q;
	assign rsp.is_match      = out_data_q.is_match;
	assign rsp.mask_overflow = out_data_q.mask_overflow;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= skid_valid_q & push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Data
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				if (push) begin
					skid_data_q <= push_data;
				end
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule
`default_nettype wire

### sv/wildcard_mask_matcher.sv
// Wildcard mask matcher top level: control, cell chain, tail position and output buffer.
// Throughput: one item per cycle while req.ready is high.
// Each name character steps the whole cell chain at once; results on rsp are registered.
// req.ready drops only while the output register and its skid entry both hold results.
// Reset: mask empty, overflow flag clear, only position zero active; no clearing pass.
`default_nettype none
module wildcard_mask_matcher #(
	parameter int unsigned MAX_PATTERN = wmm_pkg::MAX_PATTERN_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	wmm_req_if.sink   req,
	wmm_rsp_if.source rsp
);
	import wmm_pkg::*;

	localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

	logic              acc;
	opcode_t           op;
	cell_ctl_t         ctl;
	logic [LW-1:0]     len_q;
	logic              overflow_q;
	logic              act_tail_q;
	logic              closed_tail;
	link_t             link [0:MAX_PATTERN];
	logic [MAX_PATTERN:0] hit;
	logic              buf_ready;
	result_t           res;

	assign acc       = req.valid & req.ready;
	assign op        = opcode_t'(req.opcode);
	assign req.ready = buf_ready;
	assign ctl.fire  = acc;
	assign ctl.op    = op;
	assign ctl.ch    = req.char_code;
	assign link[0]   = '0;

	// Cell chain, one cell per mask position
	for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
		wmm_cell #(
			.MAX_PATTERN(MAX_PATTERN),
			.POS        (p)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.len     (len_q),
			.link_in (link[p]),
			.link_out(link[p+1]),
			.hit     (hit[p])
		);
	end

	// Final position past the last mask character
	assign closed_tail      = act_tail_q | link[MAX_PATTERN].carry;
	assign hit[MAX_PATTERN] = closed_tail & (len_q == LW'(MAX_PATTERN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_tail_q <= 1'b0;
		end else if (acc) begin
			unique case (op)
				OP_CLEAR, OP_END: act_tail_q <= 1'b0;
				OP_NAME:          act_tail_q <= link[MAX_PATTERN].adv;
				OP_APPEND:        act_tail_q <= act_tail_q;
			endcase
		end
	end

	// Mask length and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			overflow_q <= 1'b0;
		end else if (acc) begin
			unique case (op)
				OP_CLEAR: begin
					len_q      <= '0;
					overflow_q <= 1'b0;
				end
				OP_APPEND: begin
					if (len_q < LW'(MAX_PATTERN)) begin
						len_q <= len_q + LW'(1);
					end else begin
						overflow_q <= 1'b1;
					end
				end
				OP_NAME, OP_END: begin
					len_q <= len_q;
				end
			endcase
		end
	end

	// Result of an end-of-name item
	assign res.is_match      = |hit;
	assign res.mask_overflow = overflow_q;

	wmm_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc && op == OP_END),
		.push_data(res),
		.ready    (buf_ready),
		.rsp      (rsp)
	);

	// Checks
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_END) |=> rsp.valid)
		else $error("end-of-name item produced no pending result");

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_CLEAR) |=> (len_q == '0 && !overflow_q && !act_tail_q))
		else $error("clear did not empty the mask");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_PATTERN))
		else $error("mask length beyond capacity");

	a_overflow_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overflow_q) |-> $past(acc && op == OP_APPEND && len_q == LW'(MAX_PATTERN)))
		else $error("overflow flag set without an append to a full mask");

endmodule
`default_nettype wire

### test/wildcard_mask_matcher_tb.sv
// Self-checking testbench for the wildcard mask matcher: predicted results under random pacing.
module wildcard_mask_matcher_tb;
	import wmm_pkg::*;

	localparam int unsigned DEPTH        = MAX_PATTERN_DEF;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned PHASE_MIN    = 48;
	localparam int unsigned SHOW_ERRORS  = 10;

	// Predicted matcher state and the results it still owes
	class match_scoreboard;
		logic [7:0]   mask_mem [DEPTH];
		int unsigned  mask_len;
		bit [DEPTH:0] reached;
		bit           overflowed;
		result_t      expected_q[$];
		int unsigned  errors;
		int unsigned  results_seen;
		int unsigned  matches_seen;
		int unsigned  overflow_seen;

		function new();
			mask_len      = 0;
			overflowed    = 1'b0;
			reached       = 1;
			errors        = 0;
			results_seen  = 0;
			matches_seen  = 0;
			overflow_seen = 0;
		endfunction

		function logic [7:0] lower(input logic [7:0] c);
			return (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
		endfunction

		// a name '*' is only taken by a mask '*', which is handled apart
		function bit char_fits(input logic [7:0] m, input logic [7:0] c);
			return (c != CH_STAR) && ((m == CH_ANY1) || (lower(m) == lower(c)));
		endfunction

		// positions reached plus those a '*' passes by matching nothing
		function bit [DEPTH:0] star_closure();
			bit [DEPTH:0] s;
			s = reached;
			for (int unsigned p = 0; p < mask_len; p++) begin
				if (s[p] && mask_mem[p] == CH_STAR) begin
					s[p+1] = 1'b1;
				end
			end
			return s;
		endfunction

		function void note_input(input opcode_t op, input logic [7:0] ch);
			bit [DEPTH:0] s;
			bit [DEPTH:0] nxt;
			result_t      r;
			case (op)
				OP_CLEAR: begin
					mask_len   = 0;
					overflowed = 1'b0;
					reached    = 1;
				end
				OP_APPEND: begin
					if (mask_len < DEPTH) begin
						mask_mem[mask_len] = ch;
						mask_len++;
					end else begin
						overflowed = 1'b1;
					end
				end
				OP_NAME: begin
					s   = star_closure();
					nxt = '0;
					for (int unsigned p = 0; p < mask_len; p++) begin
						if (s[p]) begin
							if (mask_mem[p] == CH_STAR) begin
								nxt[p] = 1'b1;
							end else if (char_fits(mask_mem[p], ch)) begin
								nxt[p+1] = 1'b1;
							end
						end
					end
					reached = nxt;
				end
				default: begin
					s               = star_closure();
					r.is_match      = s[mask_len];
					r.mask_overflow = overflowed;
					expected_q.push_back(r);
					reached = 1;
				end
			endcase
		endfunction

		function void check_result(input logic m, input logic o);
			result_t want;
			results_seen++;
			if (m === 1'b1) matches_seen++;
			if (o === 1'b1) overflow_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= SHOW_ERRORS) begin
					$display("result %0d arrived with none expected: match=%b overflow=%b",
						results_seen, m, o);
				end
				return;
			end
			want = expected_q.pop_front();
			if (m !== want.is_match || o !== want.mask_overflow) begin
				errors++;
				if (errors <= SHOW_ERRORS) begin
					$display("result %0d mismatch: expected match=%b overflow=%b,",
						results_seen, want.is_match, want.mask_overflow);
					$display("  got match=%b overflow=%b", m, o);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	wmm_req_if req_ch ();
	wmm_rsp_if rsp_ch ();

	wildcard_mask_matcher #(
		.MAX_PATTERN(DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	match_scoreboard sb;
	int unsigned     send_idle_pct;
	int unsigned     stall_pct;
	int unsigned     items_accepted;
	int unsigned     cycle_count;
	logic [7:0]      mask_q[$];

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending());
			$display("FAIL wildcard_mask_matcher");
			$finish;
		end
	end

	// Receiver stalls
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			sb.check_result(rsp_ch.is_match, rsp_ch.mask_overflow);
		end
	end

	// One item through the request channel; valid stays up for a following item
	task automatic send_item(input opcode_t op, input logic [7:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.opcode    <= op;
		req_ch.char_code <= ch;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_input(op, ch);
		items_accepted++;
	endtask

	// Hold the sender off until every owed result is back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] base;
		base = $urandom_range(1) ? CH_UPPER_A : 8'h61;
		return base + 8'($urandom_range(25));
	endfunction

	// letters come back in either case
	function automatic logic [7:0] case_flip(input logic [7:0] c);
		logic [7:0] l;
		l = c | 8'h20;
		if (l >= 8'h61 && l <= 8'h7A && $urandom_range(1)) return c ^ 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] rand_mask_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30) return CH_STAR;
		if (r < 45) return CH_ANY1;
		if (r < 85) return rand_letter();
		return rand_byte();
	endfunction

	function automatic logic [7:0] rand_name_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 80) return rand_letter();
		if (r < 90) return CH_STAR;
		return rand_byte();
	endfunction

	// Name shaped after the current mask, sometimes broken, then end of name
	task automatic send_name();
		logic [7:0] name_q[$];
		logic [7:0] extra;
		foreach (mask_q[i]) begin
			if (mask_q[i] == CH_STAR) begin
				repeat ($urandom_range(3)) name_q.push_back(rand_name_char());
			end else if (mask_q[i] == CH_ANY1) begin
				name_q.push_back(rand_byte());
			end else begin
				name_q.push_back(case_flip(mask_q[i]));
			end
		end
		if ($urandom_range(3) == 0) begin
			if (name_q.size() > 0 && $urandom_range(1)) begin
				name_q[$urandom_range(name_q.size() - 1)] = rand_byte();
			end else begin
				name_q.push_back(rand_letter());
			end
		end
		foreach (name_q[i]) begin
			// mask grows while the name is in progress
			if ($urandom_range(19) == 0) begin
				extra = rand_mask_char();
				if (mask_q.size() < DEPTH) mask_q.push_back(extra);
				send_item(OP_APPEND, extra);
			end
			send_item(OP_NAME, name_q[i]);
		end
		send_item(OP_END, rand_byte());
	endtask

	task automatic short_mask_sequence();
		int unsigned len;
		mask_q.delete();
		send_item(OP_CLEAR, rand_byte());
		len = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(6);
		repeat (len) begin
			mask_q.push_back(rand_mask_char());
			send_item(OP_APPEND, mask_q[$]);
		end
		repeat (1 + $urandom_range(2)) send_name();
	endtask

	// Mask length runs from four below capacity to six past it, so it usually overflows
	task automatic long_mask_sequence();
		int unsigned len;
		logic [7:0]  c;
		mask_q.delete();
		send_item(OP_CLEAR, rand_byte());
		len = DEPTH - 4 + $urandom_range(10);
		repeat (len) begin
			c = ($urandom_range(4) == 0) ? CH_STAR : rand_letter();
			if (mask_q.size() < DEPTH) mask_q.push_back(c);
			send_item(OP_APPEND, c);
		end
		send_name();
		send_name();
	endtask

	task automatic noise_burst();
		repeat (4 + $urandom_range(8)) send_item(opcode_t'($urandom_range(3)), rand_byte());
	endtask

	// long masks run once up front; here only short ones and noise
	task automatic random_sequence();
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 90) begin
			short_mask_sequence();
		end else begin
			noise_burst();
		end
	endtask

	// Edge cases: empty name and mask, star-only mask, zero byte, folding limits
	task automatic directed_items();
		send_item(OP_END, 8'h00);
		send_item(OP_NAME, 8'h61);
		send_item(OP_END, 8'hFF);
		send_item(OP_APPEND, CH_STAR);
		send_item(OP_END, 8'h00);
		send_item(OP_NAME, CH_STAR);
		send_item(OP_NAME, 8'h00);
		send_item(OP_END, 8'h00);
		send_item(OP_CLEAR, 8'hFF);
		send_item(OP_APPEND, 8'h41);
		send_item(OP_APPEND, CH_ANY1);
		send_item(OP_NAME, 8'h61);
		send_item(OP_NAME, 8'h7A);
		send_item(OP_APPEND, 8'h00);
		send_item(OP_NAME, 8'h00);
		send_item(OP_END, 8'h00);
		send_item(OP_NAME, 8'h41);
		send_item(OP_NAME, CH_STAR);
		send_item(OP_NAME, 8'h00);
		send_item(OP_END, 8'h00);
		// '@' and '`' sit just outside the folded range
		send_item(OP_CLEAR, 8'h00);
		send_item(OP_APPEND, 8'h40);
		send_item(OP_APPEND, 8'hFF);
		send_item(OP_NAME, 8'h60);
		send_item(OP_NAME, 8'hFF);
		send_item(OP_END, 8'hFF);
	endtask

	// Main sequence
	initial begin
		int unsigned target;
		sb                = new();
		clk               = 1'b0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.opcode     = OP_CLEAR;
		req_ch.char_code  = 8'h00;
		rsp_ch.ready      = 1'b0;
		send_idle_pct     = 0;
		stall_pct         = 0;
		items_accepted    = 0;
		cycle_count       = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();

		// pacing phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 19; stall_pct = 19; end
			endcase
			if (ph == 0) long_mask_sequence();
			// overall budget split across phases, each phase still gets some items
			target = RANDOM_ITEMS * (ph + 1) / 4;
			if (target < items_accepted + PHASE_MIN) target = items_accepted + PHASE_MIN;
			while (items_accepted < target) random_sequence();
		end

		drain_results();
		repeat (8) @(posedge clk);
		sb.errors += sb.pending();

		$display("Covered %0d items over four pacing phases; %0d results checked, %0d matches.",
			items_accepted, sb.results_seen, sb.matches_seen);
		$display("Results flagged with mask overflow: %0d; mismatches: %0d.",
			sb.overflow_seen, sb.errors);
		if (sb.errors == 0) begin
			$display("PASS wildcard_mask_matcher");
		end else begin
			$display("FAIL wildcard_mask_matcher");
		end
		$finish;
	end
endmodule

### wildcard_mask_matcher.f
sv/wmm_pkg.sv
sv/wmm_ifs.sv
sv/wmm_cell.sv
sv/wmm_out_buf.sv
sv/wildcard_mask_matcher.sv
test/wildcard_mask_matcher_tb.sv
